// ===== hdl/lbbr_pkg.sv =====
package lbbr_pkg;

   localparam int unsigned MAX_LEN_DEFAULT = 4096;

   localparam logic [7:0] OPEN_ROUND   = 8'h28;
   localparam logic [7:0] CLOSE_ROUND  = 8'h29;
   localparam logic [7:0] OPEN_SQUARE  = 8'h5B;
   localparam logic [7:0] CLOSE_SQUARE = 8'h5D;

   typedef struct packed {
      logic [7:0] char_code;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [11:0] run_start;
      logic [12:0] run_length;
      logic        too_long;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_step;
      logic take;
      logic step;
      logic mark_top;
      logic scan_start;
      logic scan_step;
      logic load_rsp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_done;
      logic match;
      logic last;
      logic scan_done;
      logic rsp_busy;
   } status_type;

   function automatic logic pairs_with(input logic [7:0] opener, input logic [7:0] closer);
      return ((opener == OPEN_ROUND) && (closer == CLOSE_ROUND)) ||
             ((opener == OPEN_SQUARE) && (closer == CLOSE_SQUARE));
   endfunction

endpackage

// ===== hdl/longest_balanced_bracket_run_unit.sv =====
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_ready   req_data  (lbbr_pkg::req_type)
// rsp_      out        rsp_valid/rsp_ready   rsp_data  (lbbr_pkg::rsp_type)
//
// A non-matching byte passes states S_IDLE and S_STEP; a closing bracket that pops the stack
// also passes S_MARK, as the stack and mark memories are single-port.
// The last byte adds a mark scan over the bytes held and then S_EMIT, which loads the result.
// After reset a clearing pass zeroes every mark memory entry before req_ready rises.
// A result waiting on rsp_ready holds back only the next string's result, not its bytes.
module longest_balanced_bracket_run_unit #(
   parameter int unsigned MAX_LEN = lbbr_pkg::MAX_LEN_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lbbr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lbbr_pkg::rsp_type rsp_data
);

   lbbr_pkg::cmd_type    cmd;
   lbbr_pkg::status_type status;

   lbbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lbbr_datapath #(
      .MAX_LEN (MAX_LEN)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// ===== hdl/lbbr_ctrl.sv =====
module lbbr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lbbr_pkg::status_type   status,
   output lbbr_pkg::cmd_type      cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_STEP,
      S_MARK,
      S_SCAN,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            cmd.step = 1'b1;
            if (status.match) begin
               state_in = S_MARK;
            end else if (status.last) begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_MARK: begin
            cmd.mark_top = 1'b1;
            if (status.last) begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!status.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/lbbr_datapath.sv =====
module lbbr_datapath #(
   parameter int unsigned MAX_LEN = lbbr_pkg::MAX_LEN_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lbbr_pkg::req_type    req_data,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output lbbr_pkg::rsp_type    rsp_data,
   input  lbbr_pkg::cmd_type    cmd,
   output lbbr_pkg::status_type status
);

   localparam int unsigned POS_W = $clog2(MAX_LEN);
   localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);
   localparam int unsigned ENT_W = POS_W + 8;

   // Stack entry: position above, byte below.
   logic [ENT_W-1:0] stack_mem [MAX_LEN];
   logic             marks_mem [MAX_LEN];

   logic [7:0]       char_ff, char_in;
   logic             last_ff, last_in;
   logic             skip_ff, skip_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] sp_ff, sp_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             ovf_ff, ovf_in;
   logic [POS_W-1:0] clr_idx_ff, clr_idx_in;
   logic [CNT_W-1:0] scan_idx_ff, scan_idx_in;
   logic             rd_valid_ff, rd_valid_in;
   logic [POS_W-1:0] rd_pos_ff, rd_pos_in;
   logic [CNT_W-1:0] cur_len_ff, cur_len_in;
   logic [POS_W-1:0] cur_start_ff, cur_start_in;
   logic [CNT_W-1:0] best_len_ff, best_len_in;
   logic [POS_W-1:0] best_start_ff, best_start_in;
   logic             rsp_valid_ff, rsp_valid_in;
   lbbr_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [ENT_W-1:0] top_ff;
   logic             mark_rd_ff;

   logic [CNT_W-1:0] sp_dec;
   logic [POS_W-1:0] top_pos;
   logic             match;
   logic             full;
   logic             scan_issue;
   logic [CNT_W-1:0] run_len_next;
   logic             stk_we;
   logic             mk_we;
   logic             mk_re;
   logic [POS_W-1:0] mk_addr;
   logic             mk_wdata;

   assign sp_dec       = CNT_W'(sp_ff - 1'b1);
   assign top_pos      = top_ff[ENT_W-1:8];
   assign match        = !skip_ff && (sp_ff != '0) && lbbr_pkg::pairs_with(top_ff[7:0], char_ff);
   assign full         = (cnt_ff == CNT_W'(MAX_LEN));
   assign scan_issue   = (scan_idx_ff != cnt_ff);
   assign run_len_next = CNT_W'(cur_len_ff + 1'b1);

   always_comb begin
      char_in       = char_ff;
      last_in       = last_ff;
      skip_in       = skip_ff;
      pos_in        = pos_ff;
      sp_in         = sp_ff;
      cnt_in        = cnt_ff;
      ovf_in        = ovf_ff;
      clr_idx_in    = clr_idx_ff;
      scan_idx_in   = scan_idx_ff;
      rd_valid_in   = rd_valid_ff;
      rd_pos_in     = rd_pos_ff;
      cur_len_in    = cur_len_ff;
      cur_start_in  = cur_start_ff;
      best_len_in   = best_len_ff;
      best_start_in = best_start_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      stk_we        = 1'b0;
      mk_we         = 1'b0;
      mk_re         = 1'b0;
      mk_addr       = clr_idx_ff;
      mk_wdata      = 1'b0;

      if (cmd.clear_step) begin
         mk_we      = 1'b1;
         clr_idx_in = POS_W'(clr_idx_ff + 1'b1);
      end

      if (cmd.take) begin
         char_in = req_data.char_code;
         last_in = req_data.is_last;
         if (full) begin
            skip_in = 1'b1;
            ovf_in  = 1'b1;
         end else begin
            skip_in = 1'b0;
            pos_in  = cnt_ff[POS_W-1:0];
            cnt_in  = CNT_W'(cnt_ff + 1'b1);
         end
      end

      if (cmd.step && !skip_ff) begin
         if (match) begin
            mk_we    = 1'b1;
            mk_addr  = pos_ff;
            mk_wdata = 1'b1;
            sp_in    = sp_dec;
         end else begin
            stk_we = 1'b1;
            sp_in  = CNT_W'(sp_ff + 1'b1);
         end
      end

      if (cmd.mark_top) begin
         mk_we    = 1'b1;
         mk_addr  = top_pos;
         mk_wdata = 1'b1;
      end

      if (cmd.scan_start) begin
         scan_idx_in   = '0;
         rd_valid_in   = 1'b0;
         cur_len_in    = '0;
         cur_start_in  = '0;
         best_len_in   = '0;
         best_start_in = '0;
      end

      // Each scanned mark is read and cleared in the same cycle.
      if (cmd.scan_step) begin
         rd_valid_in = scan_issue;
         if (scan_issue) begin
            mk_we       = 1'b1;
            mk_re       = 1'b1;
            mk_addr     = scan_idx_ff[POS_W-1:0];
            rd_pos_in   = scan_idx_ff[POS_W-1:0];
            scan_idx_in = CNT_W'(scan_idx_ff + 1'b1);
         end
         if (rd_valid_ff) begin
            if (mark_rd_ff) begin
               cur_len_in = run_len_next;
               if (cur_len_ff == '0) begin
                  cur_start_in = rd_pos_ff;
               end
               // Strictly longer only, so the earliest of equal runs stays.
               if (run_len_next > best_len_ff) begin
                  best_len_in   = run_len_next;
                  best_start_in = (cur_len_ff == '0) ? rd_pos_ff : cur_start_ff;
               end
            end else begin
               cur_len_in = '0;
            end
         end
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         if (ovf_ff) begin
            rsp_data_in.run_start  = '0;
            rsp_data_in.run_length = '0;
            rsp_data_in.too_long   = 1'b1;
         end else begin
            rsp_data_in.run_start  = 12'(best_start_ff);
            rsp_data_in.run_length = 13'(best_len_ff);
            rsp_data_in.too_long   = 1'b0;
         end
         sp_in  = '0;
         cnt_in = '0;
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[sp_ff[POS_W-1:0]] <= {pos_ff, char_ff};
      end
      if (cmd.take) begin
         top_ff <= stack_mem[sp_dec[POS_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (mk_we) begin
         marks_mem[mk_addr] <= mk_wdata;
      end
      if (mk_re) begin
         mark_rd_ff <= marks_mem[mk_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff        <= '0;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         clr_idx_ff   <= '0;
         scan_idx_ff  <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sp_ff        <= sp_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         clr_idx_ff   <= clr_idx_in;
         scan_idx_ff  <= scan_idx_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      char_ff       <= char_in;
      last_ff       <= last_in;
      skip_ff       <= skip_in;
      pos_ff        <= pos_in;
      rd_pos_ff     <= rd_pos_in;
      cur_len_ff    <= cur_len_in;
      cur_start_ff  <= cur_start_in;
      best_len_ff   <= best_len_in;
      best_start_ff <= best_start_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign status.clear_done = (clr_idx_ff == POS_W'(MAX_LEN - 1));
   assign status.match      = match;
   assign status.last       = last_ff;
   assign status.scan_done  = !scan_issue && !rd_valid_ff;
   assign status.rsp_busy   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_stack_within_count: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= cnt_ff)
      else $error("stack deeper than the number of positions taken");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_LEN))
      else $error("position count beyond maximum length");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (CNT_W'(rd_pos_ff) < cnt_ff))
      else $error("scanned position outside the string");

   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> (rsp_valid_ff && (sp_ff == '0) && (cnt_ff == '0) && !ovf_ff))
      else $error("string state not cleared after result");

endmodule
